@@ sv/bbpc_pkg.sv @@
package bbpc_pkg;

	localparam int KIND_W = 2;
	localparam int LEN_W = 13;
	localparam int OFF_W = 12;
	localparam int DEFAULT_CAPACITY = 4096;

	typedef enum logic [KIND_W-1:0] {
		OP_RESERVE = 2'd0,
		OP_COMMIT  = 2'd1,
		OP_READ    = 2'd2,
		OP_CONSUME = 2'd3
	} op_t;

	typedef struct packed {
		logic             granted;
		logic [OFF_W-1:0] offset;
		logic [LEN_W-1:0] length;
		logic             full;
		logic             empty;
	} result_t;

endpackage

@@ sv/bipartite_buffer_pointer_control_core.sv @@
// pointer control for a bipartite circular byte buffer (read, write, wrap mark)
// command channel: drive kind, length and block_start with start high; the item
// is taken at a rising edge where start is high and busy is low. busy stays low,
// so one item can be taken every cycle.
// kinds: reserve asks for a contiguous region, commit advances the write
// position, read reports the next readable region, consume retires a region.
// result channel: done strobes high for exactly one cycle with granted,
// region_offset, region_length, is_full and is_empty. an item taken is
// registered into the s1 stage and its result into result_q with done_q,
// one result per item, in order. throughput is one item per cycle: the three
// pointer registers are updated in the same cycle the item is evaluated, so
// the next item sees the new state.
// the receiver cannot stall and must take each result in its strobe cycle.
// reset (arst_n low) clears the pointers and the mark, so the buffer is empty,
// and drops any item in flight.
module bipartite_buffer_pointer_control_core #(
	parameter int CAPACITY = bbpc_pkg::DEFAULT_CAPACITY
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [bbpc_pkg::KIND_W-1:0] kind,
	input  logic [bbpc_pkg::LEN_W-1:0]  length,
	input  logic [bbpc_pkg::OFF_W-1:0]  block_start,
	output logic                        done,
	output logic                        granted,
	output logic [bbpc_pkg::OFF_W-1:0]  region_offset,
	output logic [bbpc_pkg::LEN_W-1:0]  region_length,
	output logic                        is_full,
	output logic                        is_empty
);
	import bbpc_pkg::*;

	logic             valid_s1;
	logic [KIND_W-1:0] kind_s1;
	logic [LEN_W-1:0] length_s1;
	logic [OFF_W-1:0] start_s1;
	result_t          result;
	result_t          result_q;
	logic             done_q;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			kind_s1   <= kind;
			length_s1 <= length;
			start_s1  <= block_start;
		end
	end

	bbpc_ptr_unit #(
		.CAPACITY(CAPACITY)
	) u_ptr (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.kind_s1  (kind_s1),
		.length_s1(length_s1),
		.start_s1 (start_s1),
		.result   (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			result_q <= result;
		end
	end

	assign done          = done_q;
	assign granted       = result_q.granted;
	assign region_offset = result_q.offset;
	assign region_length = result_q.length;
	assign is_full       = result_q.full;
	assign is_empty      = result_q.empty;

endmodule

@@ sv/bbpc_ptr_unit.sv @@
module bbpc_ptr_unit #(
	parameter int CAPACITY = bbpc_pkg::DEFAULT_CAPACITY
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        valid_s1,
	input  logic [bbpc_pkg::KIND_W-1:0] kind_s1,
	input  logic [bbpc_pkg::LEN_W-1:0]  length_s1,
	input  logic [bbpc_pkg::OFF_W-1:0]  start_s1,
	output bbpc_pkg::result_t           result
);
	import bbpc_pkg::*;

	localparam int PW = $clog2(CAPACITY + 1);
	// arithmetic width: holds position + length and start + length without overflow
	localparam int SW = ((PW > LEN_W) ? PW : LEN_W) + 1;

	logic [PW-1:0] rp_q, wp_q, wm_q;
	logic [SW-1:0] rp, wp, wm, ln, st, cap;
	logic [SW-1:0] rp_n, wp_n, wm_n;
	logic [SW-1:0] wp_plus_len, commit_len, wp_plus_commit, end_raw, end_sat;
	logic [SW-1:0] off, rlen;
	logic          granted;
	op_t           op;

	assign rp  = SW'(rp_q);
	assign wp  = SW'(wp_q);
	assign wm  = SW'(wm_q);
	assign ln  = SW'(length_s1);
	assign st  = SW'(start_s1);
	assign cap = SW'(CAPACITY);
	assign op  = op_t'(kind_s1);

	assign wp_plus_len    = wp + ln;
	assign commit_len     = (ln > cap) ? cap : ln;
	assign wp_plus_commit = wp + commit_len;
	assign end_raw        = st + ln;
	assign end_sat        = (end_raw > cap) ? cap : end_raw;

	always_comb begin
		rp_n    = rp;
		wp_n    = wp;
		wm_n    = wm;
		granted = 1'b1;
		off     = '0;
		rlen    = '0;
		case (op)
			OP_RESERVE: begin
				granted = 1'b0;
				if (wm != '0) begin
					if (wp_plus_len <= rp) begin
						granted = 1'b1;
						off     = wp;
						rlen    = ln;
					end
				end else if (wp_plus_len <= cap) begin
					granted = 1'b1;
					off     = wp;
					rlen    = ln;
				end else if (rp >= ln) begin
					granted = 1'b1;
					rlen    = ln;
				end
			end
			OP_COMMIT: begin
				// region does not fit at the end: mark and restart at zero
				if (wp_plus_commit > cap) begin
					wm_n = wp;
					wp_n = commit_len;
				end else begin
					wp_n = wp_plus_commit;
				end
			end
			OP_READ: begin
				if (wm != '0) begin
					if (rp == wm) begin
						rlen = wp;
					end else begin
						off  = rp;
						rlen = (wm > rp) ? wm - rp : '0;
					end
				end else begin
					off  = rp;
					rlen = (wp > rp) ? wp - rp : '0;
				end
			end
			OP_CONSUME: begin
				if (end_sat == wm) begin
					rp_n = '0;
					wm_n = '0;
				end else begin
					if (rp >= end_sat) begin
						wm_n = '0;
					end
					rp_n = end_sat;
				end
			end
			default: begin
				granted = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rp_q <= '0;
			wp_q <= '0;
			wm_q <= '0;
		end else if (valid_s1) begin
			rp_q <= rp_n[PW-1:0];
			wp_q <= wp_n[PW-1:0];
			wm_q <= wm_n[PW-1:0];
		end
	end

	// flags are taken after the update
	always_comb begin
		result.granted = granted;
		result.offset  = off[OFF_W-1:0];
		result.length  = rlen[LEN_W-1:0];
		result.full    = (wm_n != '0) && (rp_n == wp_n);
		result.empty   = (wm_n == '0) && (rp_n == wp_n);
	end

endmodule

@@ sv/bbpc_checker.sv @@
module bbpc_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        start,
	input logic                        busy,
	input logic [bbpc_pkg::KIND_W-1:0] kind,
	input logic                        done,
	input logic                        granted,
	input logic [bbpc_pkg::OFF_W-1:0]  region_offset,
	input logic [bbpc_pkg::LEN_W-1:0]  region_length,
	input logic                        is_full,
	input logic                        is_empty
);
	import bbpc_pkg::*;

	logic taken;
	assign taken = start && !busy;

	// every item taken is followed by its result
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		taken |=> ##1 done)
		else $error("item taken without a result");

	// no result without an item taken before it
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(taken, 2))
		else $error("result without an item");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(is_full && is_empty))
		else $error("full and empty together");

	// only reserve can be refused
	a_non_reserve_granted: assert property (@(posedge clk) disable iff (!arst_n)
		(taken && (kind != OP_RESERVE)) |=> ##1 granted)
		else $error("non-reserve item refused");

	a_refused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !granted) |-> (region_offset == '0 && region_length == '0))
		else $error("refused reserve with non-zero region");

endmodule

bind bipartite_buffer_pointer_control_core bbpc_checker u_bbpc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.kind         (kind),
	.done         (done),
	.granted      (granted),
	.region_offset(region_offset),
	.region_length(region_length),
	.is_full      (is_full),
	.is_empty     (is_empty)
);

@@ dv/bip_pointer_checker.sv @@
module bip_pointer_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic                        busy,
	input  logic [bbpc_pkg::KIND_W-1:0] kind,
	input  logic [bbpc_pkg::LEN_W-1:0]  length,
	input  logic [bbpc_pkg::OFF_W-1:0]  block_start,
	input  logic                        done,
	input  logic                        granted,
	input  logic [bbpc_pkg::OFF_W-1:0]  region_offset,
	input  logic [bbpc_pkg::LEN_W-1:0]  region_length,
	input  logic                        is_full,
	input  logic                        is_empty,
	output int                          fault_count
);
	timeunit 1ns;
	timeprecision 1ps;
	import bbpc_pkg::*;

	localparam int unsigned CAP = DEFAULT_CAPACITY;

	int unsigned rd_pos;
	int unsigned wr_pos;
	int unsigned mark_pos;
	result_t     awaited[$];
	int          mismatches;
	int          awaiting;

	assign fault_count = mismatches + awaiting;

	function automatic int unsigned clip_to_cap(int unsigned v);
		return (v > CAP) ? CAP : v;
	endfunction

	// updates the pointer state and returns what the block should report
	function automatic result_t apply_op(op_t op, logic [LEN_W-1:0] len,
			logic [OFF_W-1:0] st);
		int unsigned l;
		int unsigned fin;
		int unsigned off;
		int unsigned rlen;
		logic        g;
		result_t     r;
		g = 1'b1;
		off = 0;
		rlen = 0;
		l = 32'(len);
		case (op)
			OP_RESERVE: begin
				g = 1'b0;
				if (mark_pos != 0) begin
					if (wr_pos + l <= rd_pos) begin
						g = 1'b1;
						off = wr_pos;
						rlen = l;
					end
				end else if (wr_pos + l <= CAP) begin
					g = 1'b1;
					off = wr_pos;
					rlen = l;
				end else if (rd_pos >= l) begin
					g = 1'b1;
					off = 0;
					rlen = l;
				end
			end
			OP_COMMIT: begin
				l = clip_to_cap(l);
				if (wr_pos + l > CAP) begin
					mark_pos = wr_pos;
					wr_pos = l;
				end else begin
					wr_pos = wr_pos + l;
				end
			end
			OP_READ: begin
				if (mark_pos != 0 && rd_pos == mark_pos) begin
					off = 0;
					rlen = wr_pos;
				end else if (mark_pos != 0) begin
					off = rd_pos;
					rlen = (mark_pos > rd_pos) ? mark_pos - rd_pos : 0;
				end else begin
					off = rd_pos;
					rlen = (wr_pos > rd_pos) ? wr_pos - rd_pos : 0;
				end
			end
			default: begin
				fin = clip_to_cap(32'(st) + l);
				if (fin == mark_pos) begin
					rd_pos = 0;
					mark_pos = 0;
				end else begin
					// retiring up to a point at or behind the reader drops the wrap
					if (rd_pos >= fin)
						mark_pos = 0;
					rd_pos = fin;
				end
			end
		endcase
		r.granted = g;
		r.offset = off[OFF_W-1:0];
		r.length = rlen[LEN_W-1:0];
		r.full = (mark_pos != 0) && (rd_pos == wr_pos);
		r.empty = (mark_pos == 0) && (rd_pos == wr_pos);
		return r;
	endfunction

	task automatic note_fault(result_t want, result_t got, bit orphan);
		mismatches++;
		if (mismatches <= 10) begin
			if (orphan) begin
				$write("%0t: unexpected result granted=%0b offset=%0d length=%0d",
					$realtime, got.granted, got.offset, got.length);
				$display(" full=%0b empty=%0b", got.full, got.empty);
			end else begin
				$write("%0t: expected granted=%0b offset=%0d length=%0d",
					$realtime, want.granted, want.offset, want.length);
				$write(" full=%0b empty=%0b", want.full, want.empty);
				$write(", got granted=%0b offset=%0d length=%0d",
					got.granted, got.offset, got.length);
				$display(" full=%0b empty=%0b", got.full, got.empty);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t got;
		result_t want;
		if (!arst_n) begin
			rd_pos = 0;
			wr_pos = 0;
			mark_pos = 0;
			awaited.delete();
			awaiting = 0;
		end else begin
			if (start && !busy)
				awaited.push_back(apply_op(op_t'(kind), length, block_start));
			if (done) begin
				got = '{granted, region_offset, region_length, is_full, is_empty};
				if (awaited.size() == 0) begin
					note_fault(got, got, 1'b1);
				end else begin
					want = awaited.pop_front();
					if (got !== want)
						note_fault(want, got, 1'b0);
				end
			end
			awaiting = awaited.size();
		end
	end

endmodule

@@ dv/testbench.sv @@
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import bbpc_pkg::*;

	localparam int ITEM_TARGET = 750;
	localparam int CYCLE_LIMIT = 400000;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic [KIND_W-1:0] kind;
	logic [LEN_W-1:0]  length;
	logic [OFF_W-1:0]  block_start;
	logic              done;
	logic              granted;
	logic [OFF_W-1:0]  region_offset;
	logic [LEN_W-1:0]  region_length;
	logic              is_full;
	logic              is_empty;
	int                fault_count;
	int                sent;
	int                seen;
	int                cycles = 0;
	logic              seen_granted;
	logic [OFF_W-1:0]  seen_offset;
	logic [LEN_W-1:0]  seen_length;

	bipartite_buffer_pointer_control_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.kind(kind),
		.length(length),
		.block_start(block_start),
		.done(done),
		.granted(granted),
		.region_offset(region_offset),
		.region_length(region_length),
		.is_full(is_full),
		.is_empty(is_empty)
	);

	bip_pointer_checker watch (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.kind(kind),
		.length(length),
		.block_start(block_start),
		.done(done),
		.granted(granted),
		.region_offset(region_offset),
		.region_length(region_length),
		.is_full(is_full),
		.is_empty(is_empty),
		.fault_count(fault_count)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("bipartite_buffer_pointer_control_core: mismatch");
			$finish;
		end
	end

	// last result seen, so that follow-up items can be built from it
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen <= 0;
		end else if (done) begin
			seen <= seen + 1;
			seen_granted <= granted;
			seen_offset <= region_offset;
			seen_length <= region_length;
		end
	end

	function automatic int gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// called at a falling edge, returns at the falling edge after the item is taken
	task automatic issue(op_t op, int len, int st);
		kind = op;
		length = len[LEN_W-1:0];
		block_start = st[OFF_W-1:0];
		start = 1'b1;
		do
			@(posedge clk);
		while (busy);
		sent++;
		@(negedge clk);
	endtask

	task automatic pause(int n);
		if (n > 0) begin
			start = 1'b0;
			repeat (n) @(negedge clk);
		end
	endtask

	task automatic step(op_t op, int len, int st);
		issue(op, len, st);
		pause(gap());
	endtask

	task automatic settle();
		start = 1'b0;
		while (seen != sent)
			@(negedge clk);
	endtask

	initial begin
		int l;
		int n;
		start = 1'b0;
		kind = OP_RESERVE;
		length = '0;
		block_start = '0;
		arst_n = 1'b0;
		sent = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		pause(2);

		// directed: extremes, wraps, saturation and the odd states
		step(OP_READ, 0, 0);
		step(OP_RESERVE, 0, 0);
		step(OP_RESERVE, 4096, 4095);
		step(OP_RESERVE, 4097, 0);
		step(OP_RESERVE, 8191, 0);
		step(OP_COMMIT, 4096, 0);
		step(OP_READ, 0, 0);
		step(OP_RESERVE, 1, 0);
		step(OP_CONSUME, 4096, 0);
		step(OP_READ, 0, 0);
		step(OP_COMMIT, 8191, 0);
		step(OP_RESERVE, 0, 0);
		step(OP_READ, 0, 0);
		step(OP_CONSUME, 8191, 4095);
		step(OP_COMMIT, 100, 0);
		step(OP_CONSUME, 50, 0);
		step(OP_READ, 0, 0);
		step(OP_RESERVE, 30, 0);
		step(OP_CONSUME, 0, 200);
		step(OP_READ, 0, 0);
		step(OP_CONSUME, 0, 4000);
		step(OP_CONSUME, 0, 300);
		step(OP_READ, 0, 0);
		step(OP_RESERVE, 4095, 0);
		step(OP_CONSUME, 100, 0);

		while (sent < ITEM_TARGET) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: begin
					// reserve, then commit what was granted
					l = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 4096)
						: $urandom_range(1, 512);
					settle();
					issue(OP_RESERVE, l, $urandom_range(0, 4095));
					settle();
					if (seen_granted) begin
						pause(gap());
						issue(OP_COMMIT, l, $urandom_range(0, 4095));
					end
				end
				4, 5, 6: begin
					// read, then retire all or part of the readable region
					settle();
					issue(OP_READ, $urandom_range(0, 8191), $urandom_range(0, 4095));
					settle();
					if (seen_length != 0) begin
						l = ($urandom_range(0, 4) != 0) ? int'(seen_length)
							: $urandom_range(0, int'(seen_length));
						pause(gap());
						issue(OP_CONSUME, l, int'(seen_offset));
					end
				end
				default: begin
					n = $urandom_range(1, 6);
					repeat (n) begin
						l = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8191)
							: $urandom_range(0, 600);
						issue(op_t'($urandom_range(0, 3)), l, $urandom_range(0, 4095));
						pause(gap());
					end
				end
			endcase
			pause(gap());
		end

		settle();
		repeat (8) @(negedge clk);
		if (fault_count == 0)
			$display("bipartite_buffer_pointer_control_core: match");
		else
			$display("bipartite_buffer_pointer_control_core: mismatch");
		$finish;
	end

endmodule

@@ filelist.f @@
sv/bbpc_pkg.sv
sv/bbpc_ptr_unit.sv
sv/bipartite_buffer_pointer_control_core.sv
sv/bbpc_checker.sv
dv/bip_pointer_checker.sv
dv/testbench.sv
